@@ rtl/astok_pkg.sv @@
package astok_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LINE_BITS     = 24;
    localparam int MAX_TOKENS    = 3;

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_COMMENT = 3'd1,
        M_IDENT   = 3'd2,
        M_ZERO    = 3'd3,
        M_CHEX    = 3'd4,
        M_NUM     = 3'd5,
        M_STRING  = 3'd6
    } t_mode;

    localparam logic [3:0] K_EOF     = 4'd0;
    localparam logic [3:0] K_NEWLINE = 4'd1;
    localparam logic [3:0] K_COMMA   = 4'd2;
    localparam logic [3:0] K_COLON   = 4'd3;
    localparam logic [3:0] K_LBRACK  = 4'd4;
    localparam logic [3:0] K_RBRACK  = 4'd5;
    localparam logic [3:0] K_LPAREN  = 4'd6;
    localparam logic [3:0] K_RPAREN  = 4'd7;
    localparam logic [3:0] K_PLUS    = 4'd8;
    localparam logic [3:0] K_MINUS   = 4'd9;
    localparam logic [3:0] K_STAR    = 4'd10;
    localparam logic [3:0] K_SLASH   = 4'd11;
    localparam logic [3:0] K_STRING  = 4'd12;
    localparam logic [3:0] K_NUMBER  = 4'd13;
    localparam logic [3:0] K_IDENT   = 4'd14;
    localparam logic [3:0] K_ERROR   = 4'd15;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_INVALID  = 2'd1;
    localparam logic [1:0] E_EMPTYHEX = 2'd2;
    localparam logic [1:0] E_UNCLOSED = 2'd3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [31:0] token_value;
        logic [23:0] line_number;
        logic [23:0] text_offset;
        logic [23:0] text_length;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_out_word;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LINE_BITS-1:0]     t_line;

    // token record inside the block, before output formatting
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        t_line       line;
        t_pos        off;
        t_pos        len;
        logic [1:0]  err;
        logic        last;
    } t_tok;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0]             count;
        t_tok [MAX_TOKENS-1:0]  tok;
    } t_group;

    localparam int GROUP_BITS = $bits(t_group);

    function automatic logic is_sym_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
               c == 8'h5f || c == 8'h2e || c == 8'h24 || c == 8'h40;
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return 5'(c[2:0]) + 5'd9;
        return 5'd16;
    endfunction

    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        unique case (c)
            8'h2c:   return K_COMMA;
            8'h3a:   return K_COLON;
            8'h5b:   return K_LBRACK;
            8'h5d:   return K_RBRACK;
            8'h28:   return K_LPAREN;
            8'h29:   return K_RPAREN;
            8'h2b:   return K_PLUS;
            8'h2d:   return K_MINUS;
            8'h2a:   return K_STAR;
            8'h2f:   return K_SLASH;
            default: return K_EOF;
        endcase
    endfunction

endpackage

@@ rtl/astok_front.sv @@
module astok_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  astok_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output astok_pkg::t_group    o_group
);

    astok_pkg::t_mode r_mode, n_mode;
    logic [31:0]      r_hex, n_hex, r_dec, n_dec;
    logic             r_seen, n_seen, r_dq, n_dq;
    astok_pkg::t_line r_line, n_line;
    astok_pkg::t_pos  r_pos, r_start, n_start;

    logic             take;
    logic [1:0]       cnt;
    astok_pkg::t_tok  toks [astok_pkg::MAX_TOKENS];
    astok_pkg::t_group grp;

    assign o_stall = i_stall;
    assign take    = i_valid && !i_stall;

    always_comb begin
        logic [7:0]       c;
        logic             consumed, relex, last;
        logic [4:0]       h;
        logic [3:0]       pk;
        astok_pkg::t_pos  p, pn;
        astok_pkg::t_mode m;

        c        = i_word.source_byte;
        last     = i_word.is_last;
        p        = r_pos;
        pn       = r_pos + 1'b1;
        h        = astok_pkg::hex_val(c);
        pk       = astok_pkg::punct_kind(c);
        consumed = 1'b0;
        relex    = 1'b0;
        cnt      = '0;
        for (int k = 0; k < astok_pkg::MAX_TOKENS; k++) toks[k] = '0;
        n_mode  = r_mode;
        n_hex   = r_hex;
        n_dec   = r_dec;
        n_seen  = r_seen;
        n_dq    = r_dq;
        n_line  = r_line;
        n_start = r_start;
        m       = r_mode;

        if (m == astok_pkg::M_ZERO) begin
            if (c == 8'h78 || c == 8'h58) begin
                m        = astok_pkg::M_CHEX;
                n_hex    = '0;
                n_seen   = 1'b0;
                consumed = 1'b1;
            end else begin
                m = astok_pkg::M_NUM;
            end
        end

        // first stage: handle the open token, possibly closing it
        if (!consumed) begin
            unique case (m)
                astok_pkg::M_IDLE: relex = 1'b1;
                astok_pkg::M_COMMENT: begin
                    if (c == 8'h0a) relex = 1'b1;
                    else if (c == 8'h0d) m = astok_pkg::M_IDLE;
                    if (c == 8'h0a) m = astok_pkg::M_IDLE;
                end
                astok_pkg::M_IDENT: begin
                    if (!(astok_pkg::is_sym_char(c) || astok_pkg::is_dec(c))) begin
                        toks[0] = '{astok_pkg::K_IDENT, 32'd0, n_line, r_start,
                                    p - r_start, astok_pkg::E_NONE, 1'b0};
                        cnt   = 2'd1;
                        m     = astok_pkg::M_IDLE;
                        relex = 1'b1;
                    end
                end
                astok_pkg::M_NUM: begin
                    if (h < 5'd16) begin
                        n_hex = {r_hex[27:0], h[3:0]};
                        if (astok_pkg::is_dec(c))
                            n_dec = r_dec * 32'd10 + 32'(c[3:0]);
                    end else if (c == 8'h68 || c == 8'h48) begin
                        toks[0] = '{astok_pkg::K_NUMBER, r_hex, n_line, r_start,
                                    pn - r_start, astok_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                        m   = astok_pkg::M_IDLE;
                    end else begin
                        toks[0] = '{astok_pkg::K_NUMBER, r_dec, n_line, r_start,
                                    p - r_start, astok_pkg::E_NONE, 1'b0};
                        cnt   = 2'd1;
                        m     = astok_pkg::M_IDLE;
                        relex = 1'b1;
                    end
                end
                astok_pkg::M_CHEX: begin
                    if (h < 5'd16) begin
                        n_hex  = {r_hex[27:0], h[3:0]};
                        n_seen = 1'b1;
                    end else begin
                        if (r_seen)
                            toks[0] = '{astok_pkg::K_NUMBER, r_hex, n_line, r_start,
                                        p - r_start, astok_pkg::E_NONE, 1'b0};
                        else
                            toks[0] = '{astok_pkg::K_ERROR, 32'd0, n_line, r_start,
                                        p - r_start, astok_pkg::E_EMPTYHEX, 1'b0};
                        cnt   = 2'd1;
                        m     = astok_pkg::M_IDLE;
                        relex = 1'b1;
                    end
                end
                astok_pkg::M_STRING: begin
                    if (c == (r_dq ? 8'h22 : 8'h27)) begin
                        toks[0] = '{astok_pkg::K_STRING, 32'd0, n_line, r_start,
                                    p - r_start, astok_pkg::E_NONE, 1'b0};
                        cnt = 2'd1;
                        m   = astok_pkg::M_IDLE;
                    end else if (c == 8'h0a && r_line != '1) begin
                        n_line = r_line + 1'b1;
                    end
                end
                default: m = astok_pkg::M_IDLE;
            endcase
        end

        // second stage: lex the byte from idle
        if (relex) begin
            if (pk != astok_pkg::K_EOF) begin
                toks[cnt] = '{pk, 32'd0, n_line, p, astok_pkg::t_pos'(1),
                              astok_pkg::E_NONE, 1'b0};
                cnt = cnt + 2'd1;
            end else if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
            end else if (c == 8'h0a) begin
                toks[cnt] = '{astok_pkg::K_NEWLINE, 32'd0, n_line, p,
                              astok_pkg::t_pos'(1), astok_pkg::E_NONE, 1'b0};
                cnt = cnt + 2'd1;
                if (n_line != '1) n_line = n_line + 1'b1;
            end else if (c == 8'h3b) begin
                m = astok_pkg::M_COMMENT;
            end else if (c == 8'h22 || c == 8'h27) begin
                m       = astok_pkg::M_STRING;
                n_dq    = (c == 8'h22);
                n_start = pn;
            end else if (astok_pkg::is_dec(c)) begin
                n_start = p;
                n_hex   = 32'(c[3:0]);
                n_dec   = 32'(c[3:0]);
                m       = (c == 8'h30) ? astok_pkg::M_ZERO : astok_pkg::M_NUM;
            end else if (astok_pkg::is_sym_char(c)) begin
                n_start = p;
                m       = astok_pkg::M_IDENT;
            end else begin
                toks[cnt] = '{astok_pkg::K_ERROR, 32'd0, n_line, p,
                              astok_pkg::t_pos'(1), astok_pkg::E_INVALID, 1'b0};
                cnt = cnt + 2'd1;
            end
        end

        // end of text closes any open token and adds the eof word
        if (last) begin
            unique case (m)
                astok_pkg::M_IDENT: begin
                    toks[cnt] = '{astok_pkg::K_IDENT, 32'd0, n_line, n_start,
                                  pn - n_start, astok_pkg::E_NONE, 1'b0};
                    cnt = cnt + 2'd1;
                end
                astok_pkg::M_NUM, astok_pkg::M_ZERO: begin
                    toks[cnt] = '{astok_pkg::K_NUMBER, n_dec, n_line, n_start,
                                  pn - n_start, astok_pkg::E_NONE, 1'b0};
                    cnt = cnt + 2'd1;
                end
                astok_pkg::M_CHEX: begin
                    if (n_seen)
                        toks[cnt] = '{astok_pkg::K_NUMBER, n_hex, n_line, n_start,
                                      pn - n_start, astok_pkg::E_NONE, 1'b0};
                    else
                        toks[cnt] = '{astok_pkg::K_ERROR, 32'd0, n_line, n_start,
                                      pn - n_start, astok_pkg::E_EMPTYHEX, 1'b0};
                    cnt = cnt + 2'd1;
                end
                astok_pkg::M_STRING: begin
                    toks[cnt] = '{astok_pkg::K_ERROR, 32'd0, n_line, n_start,
                                  pn - n_start, astok_pkg::E_UNCLOSED, 1'b0};
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
            toks[cnt] = '{astok_pkg::K_EOF, 32'd0, n_line, pn, '0,
                          astok_pkg::E_NONE, 1'b0};
            cnt = cnt + 2'd1;
        end
        n_mode = m;

        for (int k = 0; k < astok_pkg::MAX_TOKENS; k++) begin
            toks[k].last = (2'(k + 1) == cnt);
            grp.tok[k]   = toks[k];
        end
        grp.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= astok_pkg::M_IDLE;
            r_hex   <= '0;
            r_dec   <= '0;
            r_seen  <= 1'b0;
            r_dq    <= 1'b0;
            r_line  <= astok_pkg::t_line'(1);
            r_pos   <= '0;
            r_start <= '0;
        end else if (take) begin
            if (i_word.is_last) begin
                r_mode  <= astok_pkg::M_IDLE;
                r_hex   <= '0;
                r_dec   <= '0;
                r_seen  <= 1'b0;
                r_dq    <= 1'b0;
                r_line  <= astok_pkg::t_line'(1);
                r_pos   <= '0;
                r_start <= '0;
            end else begin
                r_mode  <= n_mode;
                r_hex   <= n_hex;
                r_dec   <= n_dec;
                r_seen  <= n_seen;
                r_dq    <= n_dq;
                r_line  <= n_line;
                r_pos   <= r_pos + 1'b1;
                r_start <= n_start;
            end
        end
    end

    // bytes that cause nothing are dropped here
    assign o_valid = take && (cnt != 2'd0);
    assign o_group = grp;

endmodule

@@ rtl/astok_ram.sv @@
module astok_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/astok_back.sv @@
module astok_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  astok_pkg::t_group    i_group,
    output logic                 o_full,
    output logic                 o_valid,
    input  logic                 i_stall,
    output astok_pkg::t_out_word o_word
);

    // four-entry group queue; head group is registered then serialized
    logic [2:0] r_cnt, n_cnt;
    logic [1:0] r_wp, r_rp, n_rp;
    logic       r_hv;
    logic [1:0] r_idx;
    astok_pkg::t_group r_head, rd_group;
    logic       r_rdv;
    logic       push, pop, head_done, load;
    astok_pkg::t_tok t;

    astok_ram #(.WIDTH(astok_pkg::GROUP_BITS), .DEPTH(4)) u_q (
        .i_clk  (i_clk),
        .i_we   (push),
        .i_waddr(r_wp),
        .i_wdata(i_group),
        .i_raddr(n_rp),
        .o_rdata(rd_group)
    );

    // room must cover one in flight plus the pending read
    assign o_full    = r_cnt >= 3'd3;
    assign push      = i_valid;
    assign t         = r_head.tok[r_idx];
    assign o_valid   = r_hv;
    assign head_done = r_hv && !i_stall && t.last;
    // the ram output is valid the cycle after its address settles on a nonempty queue
    assign load      = (!r_hv || head_done) && r_rdv;
    assign pop       = load;
    assign n_rp      = pop ? r_rp + 2'd1 : r_rp;
    assign n_cnt     = r_cnt + {2'b0, push} - {2'b0, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_hv  <= 1'b0;
            r_idx <= '0;
            r_rdv <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_rp  <= n_rp;
            if (push) r_wp <= r_wp + 2'd1;
            // read data is fresh when the queue held a word at the prior read
            r_rdv <= (r_cnt - {2'b0, pop}) != 3'd0;
            if (load) begin
                r_hv  <= 1'b1;
                r_idx <= '0;
            end else if (head_done) begin
                r_hv <= 1'b0;
            end else if (r_hv && !i_stall) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_head <= rd_group;
    end

    assign o_word = '{t.kind, t.value, 24'(t.line), 24'(t.off), 24'(t.len),
                      t.err, t.last};

endmodule

@@ rtl/assembly_source_tokenizer_unit.sv @@
// Path: a byte's tokens are written into the group queue RAM, read through its
// registered output and loaded into the registered head group before they show.
// Throughput: one byte per cycle while each byte yields at most one token and
// i_stall is low; a multi-token byte is serialized from the head group, absorbed by the group queue.
// Reset: i_rst_n synchronous active low; lexer returns to idle, line 1,
// offset 0, queue empty. After a last byte the lexer resets itself.
module assembly_source_tokenizer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  astok_pkg::t_in_word  i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output astok_pkg::t_out_word o_word
);

    logic              f_valid, q_full;
    astok_pkg::t_group f_group;

    astok_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_word (i_word),
        .o_valid(f_valid),
        .i_stall(q_full),
        .o_group(f_group)
    );

    astok_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .i_group(f_group),
        .o_full (q_full),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_word (o_word)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> !q_full)
        else $error("queue push while full");

    a_group_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> f_group.count != 2'd0)
        else $error("empty group pushed");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.token_kind == astok_pkg::K_EOF) |-> o_word.last_of_run)
        else $error("eof not last of run");

endmodule

@@ bench/assembly_source_tokenizer_unit_tb.sv @@
module assembly_source_tokenizer_unit_tb;

    localparam int LIMIT = 20000;
    localparam int SETTLE = 12;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 out_stall = 1'b0;
    astok_pkg::t_in_word  in_word = '0;
    logic                 dut_stall;
    logic                 out_valid;
    astok_pkg::t_out_word out_word;

    always #5 clk = ~clk;

    assembly_source_tokenizer_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (dut_stall),
        .i_word  (in_word),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_word  (out_word)
    );

    // lexer state mirror
    astok_pkg::t_mode lx_mode;
    logic [31:0]      lx_hex;
    logic [31:0]      lx_dec;
    logic             lx_seen;
    logic             lx_dq;
    astok_pkg::t_line lx_line;
    astok_pkg::t_pos  lx_pos;
    astok_pkg::t_pos  lx_start;

    astok_pkg::t_out_word token_q[$];
    astok_pkg::t_out_word run_toks[$];
    int errors = 0;
    int tokens_seen = 0;
    int bytes_sent = 0;
    int idle_pct = 28;
    int quiet = 0;

    function automatic bit alpha_ch(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == "_" || c == "." || c == "$" || c == "@";
    endfunction

    function automatic bit dec_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [4:0] nibble(logic [7:0] c);
        if (dec_ch(c)) return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    task automatic push_tok(logic [3:0] k, logic [31:0] v, astok_pkg::t_pos off,
                            astok_pkg::t_pos len, logic [1:0] e);
        astok_pkg::t_out_word w;
        w.token_kind = k;
        w.token_value = v;
        w.line_number = lx_line;
        w.text_offset = off;
        w.text_length = len;
        w.error_code = e;
        w.last_of_run = 1'b0;
        run_toks.push_back(w);
    endtask

    task automatic bump_line();
        if (lx_line != '1) lx_line = lx_line + 1'b1;
    endtask

    task automatic clear_lexer();
        lx_mode = astok_pkg::M_IDLE;
        lx_hex = '0;
        lx_dec = '0;
        lx_seen = 1'b0;
        lx_dq = 1'b0;
        lx_line = astok_pkg::t_line'(1);
        lx_pos = '0;
        lx_start = '0;
    endtask

    task automatic lex_fresh(logic [7:0] c, astok_pkg::t_pos p);
        logic [3:0] k;
        case (c)
            ",": k = astok_pkg::K_COMMA;
            ":": k = astok_pkg::K_COLON;
            "[": k = astok_pkg::K_LBRACK;
            "]": k = astok_pkg::K_RBRACK;
            "(": k = astok_pkg::K_LPAREN;
            ")": k = astok_pkg::K_RPAREN;
            "+": k = astok_pkg::K_PLUS;
            "-": k = astok_pkg::K_MINUS;
            "*": k = astok_pkg::K_STAR;
            "/": k = astok_pkg::K_SLASH;
            default: k = astok_pkg::K_EOF;
        endcase
        if (k != astok_pkg::K_EOF) begin
            push_tok(k, 32'd0, p, astok_pkg::t_pos'(1), astok_pkg::E_NONE);
        end else if (c == " " || c == 8'h09 || c == 8'h0d) begin
        end else if (c == 8'h0a) begin
            push_tok(astok_pkg::K_NEWLINE, 32'd0, p, astok_pkg::t_pos'(1),
                     astok_pkg::E_NONE);
            bump_line();
        end else if (c == ";") begin
            lx_mode = astok_pkg::M_COMMENT;
        end else if (c == 8'h22 || c == 8'h27) begin
            lx_mode = astok_pkg::M_STRING;
            lx_dq = (c == 8'h22);
            lx_start = p + 1'b1;
        end else if (dec_ch(c)) begin
            lx_start = p;
            lx_hex = 32'(c - "0");
            lx_dec = 32'(c - "0");
            lx_mode = (c == "0") ? astok_pkg::M_ZERO : astok_pkg::M_NUM;
        end else if (alpha_ch(c)) begin
            lx_start = p;
            lx_mode = astok_pkg::M_IDENT;
        end else begin
            push_tok(astok_pkg::K_ERROR, 32'd0, p, astok_pkg::t_pos'(1),
                     astok_pkg::E_INVALID);
        end
    endtask

    task automatic close_hex(astok_pkg::t_pos e);
        if (lx_seen)
            push_tok(astok_pkg::K_NUMBER, lx_hex, lx_start, e - lx_start,
                     astok_pkg::E_NONE);
        else
            push_tok(astok_pkg::K_ERROR, 32'd0, lx_start, e - lx_start,
                     astok_pkg::E_EMPTYHEX);
    endtask

    // predicts the tokens caused by one byte and queues them
    task automatic tokenize_byte(astok_pkg::t_in_word w);
        logic [7:0] c;
        logic [4:0] h;
        astok_pkg::t_pos p, pn;
        bit used;
        c = w.source_byte;
        h = nibble(c);
        p = lx_pos;
        pn = p + 1'b1;
        used = 1'b0;
        run_toks.delete();
        if (lx_mode == astok_pkg::M_ZERO) begin
            if (c == "x" || c == "X") begin
                lx_mode = astok_pkg::M_CHEX;
                lx_hex = '0;
                lx_seen = 1'b0;
                used = 1'b1;
            end else begin
                lx_mode = astok_pkg::M_NUM;
            end
        end
        if (used) begin
        end else begin
            case (lx_mode)
                astok_pkg::M_IDLE: lex_fresh(c, p);
                astok_pkg::M_COMMENT: begin
                    if (c == 8'h0a) begin
                        lx_mode = astok_pkg::M_IDLE;
                        lex_fresh(c, p);
                    end else if (c == 8'h0d) begin
                        lx_mode = astok_pkg::M_IDLE;
                    end
                end
                astok_pkg::M_IDENT: begin
                    if (!(alpha_ch(c) || dec_ch(c))) begin
                        push_tok(astok_pkg::K_IDENT, 32'd0, lx_start, p - lx_start,
                                 astok_pkg::E_NONE);
                        lx_mode = astok_pkg::M_IDLE;
                        lex_fresh(c, p);
                    end
                end
                astok_pkg::M_NUM: begin
                    if (h < 16) begin
                        lx_hex = (lx_hex << 4) | 32'(h);
                        if (dec_ch(c)) lx_dec = lx_dec * 32'd10 + 32'(c - "0");
                    end else if (c == "h" || c == "H") begin
                        push_tok(astok_pkg::K_NUMBER, lx_hex, lx_start, pn - lx_start,
                                 astok_pkg::E_NONE);
                        lx_mode = astok_pkg::M_IDLE;
                    end else begin
                        push_tok(astok_pkg::K_NUMBER, lx_dec, lx_start, p - lx_start,
                                 astok_pkg::E_NONE);
                        lx_mode = astok_pkg::M_IDLE;
                        lex_fresh(c, p);
                    end
                end
                astok_pkg::M_CHEX: begin
                    if (h < 16) begin
                        lx_hex = (lx_hex << 4) | 32'(h);
                        lx_seen = 1'b1;
                    end else begin
                        close_hex(p);
                        lx_mode = astok_pkg::M_IDLE;
                        lex_fresh(c, p);
                    end
                end
                astok_pkg::M_STRING: begin
                    if (c == (lx_dq ? 8'h22 : 8'h27)) begin
                        push_tok(astok_pkg::K_STRING, 32'd0, lx_start, p - lx_start,
                                 astok_pkg::E_NONE);
                        lx_mode = astok_pkg::M_IDLE;
                    end else if (c == 8'h0a) begin
                        bump_line();
                    end
                end
                default: lx_mode = astok_pkg::M_IDLE;
            endcase
        end
        lx_pos = pn;
        if (w.is_last) begin
            case (lx_mode)
                astok_pkg::M_IDENT:
                    push_tok(astok_pkg::K_IDENT, 32'd0, lx_start, pn - lx_start,
                             astok_pkg::E_NONE);
                astok_pkg::M_NUM, astok_pkg::M_ZERO:
                    push_tok(astok_pkg::K_NUMBER, lx_dec, lx_start, pn - lx_start,
                             astok_pkg::E_NONE);
                astok_pkg::M_CHEX: close_hex(pn);
                astok_pkg::M_STRING:
                    push_tok(astok_pkg::K_ERROR, 32'd0, lx_start, pn - lx_start,
                             astok_pkg::E_UNCLOSED);
                default: ;
            endcase
            push_tok(astok_pkg::K_EOF, 32'd0, pn, '0, astok_pkg::E_NONE);
            clear_lexer();
        end
        if (run_toks.size() > 0) run_toks[run_toks.size()-1].last_of_run = 1'b1;
        foreach (run_toks[i]) token_q.push_back(run_toks[i]);
    endtask

    // directed rows: byte, last flag, whether the first token is typed in
    typedef struct {
        logic [7:0]           b;
        logic                 last;
        bit                   has_ref;
        astok_pkg::t_out_word ref_tok;
    } t_row;

    t_row rows[$];
    astok_pkg::t_out_word typed_q[$];

    function automatic astok_pkg::t_out_word tok(logic [3:0] k, logic [31:0] v, int ln,
                                                 int off, int len, logic [1:0] e,
                                                 bit l);
        astok_pkg::t_out_word w;
        w.token_kind = k;
        w.token_value = v;
        w.line_number = 24'(ln);
        w.text_offset = 24'(off);
        w.text_length = 24'(len);
        w.error_code = e;
        w.last_of_run = l;
        return w;
    endfunction

    task automatic add_row(logic [7:0] b, logic l);
        t_row r;
        r.b = b;
        r.last = l;
        r.has_ref = 0;
        r.ref_tok = '0;
        rows.push_back(r);
    endtask

    task automatic add_typed(logic [7:0] b, logic l, astok_pkg::t_out_word t);
        t_row r;
        r.b = b;
        r.last = l;
        r.has_ref = 1;
        r.ref_tok = t;
        rows.push_back(r);
    endtask

    task automatic add_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], close && i == s.len() - 1);
    endtask

    task automatic send(astok_pkg::t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // accepted input: predict at the same edge
    always @(posedge clk) begin
        if (rst_n && in_valid && !dut_stall) tokenize_byte(in_word);
    end

    always @(posedge clk) begin
        astok_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            tokens_seen++;
            if (token_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected token %h", out_word);
            end else begin
                want = token_q.pop_front();
                if (out_word !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h got %h", want, out_word);
                end
                if (typed_q.size() > 0 && typed_q[0].token_kind === want.token_kind &&
                    typed_q[0].text_offset === want.text_offset) begin
                    if (typed_q[0] !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display("table row: exp %h model %h", typed_q[0], want);
                    end
                    void'(typed_q.pop_front());
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !dut_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("assembly_source_tokenizer_unit verification failed");
            $finish;
        end
    end

    string pieces[16] = '{"mov", "r1", "0x1F", "0x", "12h", "9af", "4294967296",
                          "'ab'", "\"q\"", "; note\n", "\n", ",", "[", "_l$@.", "0",
                          "0xFFFFFFFFF"};

    initial begin
        astok_pkg::t_in_word w;
        string s;
        clear_lexer();
        // table: "0x" empty hex at end, punctuation, invalid, newline, comment, unclosed
        add_typed("0", 0, '0);
        rows[0].has_ref = 0;
        add_row("x", 1);
        rows[1].has_ref = 1;
        rows[1].ref_tok = tok(astok_pkg::K_ERROR, 0, 1, 0, 2, astok_pkg::E_EMPTYHEX, 0);
        add_text(",:[]()+-*/", 0);
        add_typed(8'hff, 0, tok(astok_pkg::K_ERROR, 0, 1, 10, 1, astok_pkg::E_INVALID, 1));
        add_typed(8'h00, 0, tok(astok_pkg::K_ERROR, 0, 1, 11, 1, astok_pkg::E_INVALID, 1));
        add_typed(8'h0a, 0, tok(astok_pkg::K_NEWLINE, 0, 1, 12, 1, astok_pkg::E_NONE, 1));
        add_text(";c", 0);
        add_row(8'h0d, 0);
        add_text("\t 7h 'x\n", 0);
        add_typed("z", 1, tok(astok_pkg::K_ERROR, 0, 3, 22, 3, astok_pkg::E_UNCLOSED, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i]) begin
            if (rows[i].has_ref) typed_q.push_back(rows[i].ref_tok);
            w.source_byte = rows[i].b;
            w.is_last = rows[i].last;
            send(w);
        end
        // hold the source until all tokens drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (token_q.size() != 0) @(posedge clk);

        while (bytes_sent < 140) begin
            if (bytes_sent > 60 && bytes_sent < 100) idle_pct = 0;
            else idle_pct = 28;
            if ($urandom_range(9) < 8) begin
                s = pieces[$urandom_range(15)];
                for (int i = 0; i < s.len(); i++) begin
                    w.source_byte = s[i];
                    w.is_last = 1'b0;
                    send(w);
                end
                w.source_byte = ($urandom_range(1)) ? " " : "+";
                w.is_last = ($urandom_range(7) == 0);
                send(w);
            end else begin
                w.source_byte = 8'($urandom);
                w.is_last = ($urandom_range(5) == 0);
                send(w);
            end
        end
        w.source_byte = "a";
        w.is_last = 1'b1;
        send(w);
        in_valid <= 1'b0;
        idle_pct = 28;

        @(posedge clk);
        while (token_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        $display("sent %0d source bytes, checked %0d tokens", bytes_sent, tokens_seen);
        $display("covered punctuation, numbers, strings, comments and error tokens");
        if (errors == 0 && token_q.size() == 0 && typed_q.size() == 0)
            $display("assembly_source_tokenizer_unit verification clean");
        else
            $display("assembly_source_tokenizer_unit verification failed");
        $finish;
    end

endmodule
